@@ rtl/iacc_pkg.sv @@
// Shared types and constants for the incremental accumulator stack.
// Request codes, request/response transaction structs, lane ALU control.
// No dependencies.
package iacc_pkg;

  localparam int WORD_W = 16;

  typedef enum logic [2:0] {
    REQ_LOAD_WEIGHT = 3'd0,
    REQ_LOAD_BIAS   = 3'd1,
    REQ_REFRESH     = 3'd2,
    REQ_DELTA       = 3'd3,
    REQ_POP         = 3'd4,
    REQ_READ        = 3'd5
  } req_code_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [9:0]        feature_index;
    logic [4:0]        neuron_index;
    logic signed [15:0] value;
    logic              first;
    logic              add_not_sub;
  } req_t;

  typedef struct packed {
    logic [4:0]  neuron;
    logic [14:0] activation;
    logic        last;
    logic        error;
  } rsp_t;

  typedef struct packed {
    logic [WORD_W-1:0] scale;
    logic              negate;
    logic              zero_prod;
  } alu_ctl_t;

endpackage

@@ rtl/iacc_row_ram.sv @@
// Synchronous row memory, registered read, per-lane write enables.
// Used for the weight rows and the accumulator stack. Depends on iacc_pkg.
module iacc_row_ram #(
  parameter int DEPTH = 64,
  parameter int LANES = 32,
  parameter int AW    = 6
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [AW-1:0]                         waddr,
  input  logic [LANES-1:0]                      wmask,
  input  logic [LANES-1:0][iacc_pkg::WORD_W-1:0] wdata,
  input  logic                                  re,
  input  logic [AW-1:0]                         raddr,
  output logic [LANES-1:0][iacc_pkg::WORD_W-1:0] rdata
);
  import iacc_pkg::*;

  logic [LANES-1:0][WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int l = 0; l < LANES; l++) begin
        if (wmask[l]) begin
          mem[waddr][l] <= wdata[l];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/iacc_lane_alu.sv @@
// Lane-parallel scale/accumulate unit: registered products, then add or
// subtract against a base row. Depends on iacc_pkg.
module iacc_lane_alu #(
  parameter int LANES = 32
) (
  input  logic                                   clk,
  input  logic                                   mul_en,
  input  iacc_pkg::alu_ctl_t                     ctl,
  input  logic [LANES-1:0][iacc_pkg::WORD_W-1:0] weight,
  input  logic [LANES-1:0][iacc_pkg::WORD_W-1:0] base,
  output logic [LANES-1:0][iacc_pkg::WORD_W-1:0] sum
);
  import iacc_pkg::*;

  logic [LANES-1:0][WORD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int l = 0; l < LANES; l++) begin
        logic [2*WORD_W-1:0] full;
        full = weight[l] * ctl.scale;
        prod[l] <= ctl.zero_prod ? '0 : full[WORD_W-1:0];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum[l] = ctl.negate ? (base[l] - prod[l]) : (base[l] + prod[l]);
    end
  end

endmodule

@@ rtl/incremental_accumulator_stack_core.sv @@
// Incremental accumulator stack: top level, request sequencer and bias bank.
// Depends on iacc_pkg, iacc_row_ram, iacc_lane_alu.
//
// Usage:
//   Requests arrive on req (req_valid/req_ready), one transaction per
//   operation: load weight, load bias, refresh, delta, pop, read.
//   Responses leave on rsp (rsp_valid/rsp_ready), only for a read:
//   HIDDEN transactions, neuron 0 first, last set on the final one.
// Timing:
//   Weight/bias loads, pops and rejected refresh or delta requests leave
//   ready high, so these may follow each other every cycle.
//   Refresh and delta step through a row read from the weight and stack
//   memories, registered lane products, then add and write back of the row.
//   A read registers the first response in S_RDROW, then gives one
//   response per cycle the receiver accepts.
// Reset: rst (synchronous) empties the stack and clears the error flag.
//   Weight, bias and stack contents are undefined until written; no
//   clearing pass is run.
// Stall: while rsp_ready is low the current response holds and no new
//   request is accepted until the read finishes.
module incremental_accumulator_stack_core #(
  parameter int FEATURES    = 1024,
  parameter int HIDDEN      = 32,
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  iacc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output iacc_pkg::rsp_t rsp
);
  import iacc_pkg::*;

  localparam int FA = $clog2(FEATURES);
  localparam int FW = (FA > 10) ? FA : 10;
  localparam int HA = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int NW = (HA > 5) ? HA : 5;
  localparam int SA = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WR,
    S_RDROW,
    S_OUT
  } state_t;

  typedef logic [HIDDEN-1:0][WORD_W-1:0] row_t;

  state_t         state;
  logic [CW-1:0]  cnt;
  logic           err;
  alu_ctl_t       ctl;
  logic [SA-1:0]  dest;
  logic           use_bias;
  logic           rd_empty;
  logic [HA-1:0]  lane;
  row_t           bias;

  logic           acc;
  logic [FW-1:0]  fext;
  logic [FA-1:0]  faddr;
  logic           fok;
  logic [NW-1:0]  next_idx;
  logic [HA-1:0]  nlane;
  logic           nok;
  logic           cnt_zero;
  logic           cnt_full;
  logic [CW-1:0]  cnt_m1;
  logic [SA-1:0]  top_addr;
  logic [SA-1:0]  s_raddr;
  logic [HIDDEN-1:0] w_mask;
  row_t           w_wdata;
  logic           w_we;
  row_t           w_rdata;
  row_t           s_rdata;
  row_t           base_row;
  row_t           sum_row;
  logic [HA-1:0]  lane_next;
  logic [WORD_W-1:0] act_word;
  logic [NW-1:0]  lane_ext;
  rsp_t           rsp_next;

  assign req_ready = (state == S_IDLE);
  assign acc       = req_valid && req_ready;

  assign fext     = FW'(req.feature_index);
  assign faddr    = fext[FA-1:0];
  assign fok      = int'(req.feature_index) < FEATURES;
  assign next_idx = NW'(req.neuron_index);
  assign nlane    = next_idx[HA-1:0];
  assign nok      = int'(req.neuron_index) < HIDDEN;
  assign cnt_zero = (cnt == '0);
  assign cnt_full = (cnt >= CW'(STACK_DEPTH));
  assign cnt_m1   = cnt - 1'b1;
  assign top_addr = cnt_m1[SA-1:0];

  assign w_we = acc && (req.req_type == REQ_LOAD_WEIGHT) && fok && nok;

  always_comb begin
    for (int l = 0; l < HIDDEN; l++) begin
      w_mask[l]  = (nlane == HA'(l));
      w_wdata[l] = req.value;
    end
  end

  assign s_raddr = (req.req_type == REQ_REFRESH) ? '0 : top_addr;

  iacc_row_ram #(
    .DEPTH (FEATURES),
    .LANES (HIDDEN),
    .AW    (FA)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (faddr),
    .wmask (w_mask),
    .wdata (w_wdata),
    .re    (acc),
    .raddr (faddr),
    .rdata (w_rdata)
  );

  iacc_row_ram #(
    .DEPTH (STACK_DEPTH),
    .LANES (HIDDEN),
    .AW    (SA)
  ) u_stack_ram (
    .clk   (clk),
    .we    (state == S_WR),
    .waddr (dest),
    .wmask ({HIDDEN{1'b1}}),
    .wdata (sum_row),
    .re    (acc),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign base_row = use_bias ? bias : s_rdata;

  iacc_lane_alu #(
    .LANES (HIDDEN)
  ) u_lane_alu (
    .clk    (clk),
    .mul_en (state == S_MUL),
    .ctl    (ctl),
    .weight (w_rdata),
    .base   (base_row),
    .sum    (sum_row)
  );

  // Response builder: lane 0 on entry, else the following lane.
  always_comb begin
    lane_next           = (state == S_RDROW) ? '0 : lane + 1'b1;
    act_word            = s_rdata[lane_next];
    lane_ext            = NW'(lane_next);
    rsp_next.neuron     = lane_ext[4:0];
    rsp_next.activation = (rd_empty || act_word[WORD_W-1]) ? '0 : act_word[14:0];
    rsp_next.last       = (lane_next == HA'(HIDDEN - 1));
    rsp_next.error      = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      err       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (req.req_type)
              REQ_LOAD_BIAS: begin
                if (nok) begin
                  bias[nlane] <= req.value;
                end
              end
              REQ_REFRESH: begin
                ctl.scale     <= req.value;
                ctl.negate    <= 1'b0;
                ctl.zero_prod <= !fok;
                dest          <= '0;
                if (req.first) begin
                  cnt      <= CW'(1);
                  use_bias <= 1'b1;
                  state    <= S_MUL;
                end else if (cnt_zero) begin
                  err <= 1'b1;
                end else begin
                  use_bias <= 1'b0;
                  state    <= S_MUL;
                end
              end
              REQ_DELTA: begin
                ctl.scale     <= WORD_W'(1);
                ctl.negate    <= !req.add_not_sub;
                ctl.zero_prod <= !fok;
                use_bias      <= 1'b0;
                if (cnt_zero || (req.first && cnt_full)) begin
                  err <= 1'b1;
                end else begin
                  if (req.first) begin
                    cnt  <= cnt + 1'b1;
                    dest <= cnt[SA-1:0];
                  end else begin
                    dest <= top_addr;
                  end
                  state <= S_MUL;
                end
              end
              REQ_POP: begin
                if (cnt_zero) begin
                  err <= 1'b1;
                end else begin
                  cnt <= cnt_m1;
                end
              end
              REQ_READ: begin
                if (cnt_zero) begin
                  err <= 1'b1;
                end
                rd_empty <= cnt_zero;
                state    <= S_RDROW;
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          state <= S_WR;
        end
        S_WR: begin
          state <= S_IDLE;
        end
        S_RDROW: begin
          rsp       <= rsp_next;
          lane      <= lane_next;
          rsp_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (rsp_ready) begin
            if (rsp.last) begin
              rsp_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              rsp  <= rsp_next;
              lane <= lane_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
